/* rtl/stst_pkg.sv */
// Shared types and constants for the sleep timer slot table.
// Used by stst_seq and sleep_timer_slot_table; depends on nothing.
package stst_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int CID_W     = 8;
    localparam int WAIT_W    = 20;
    localparam int NOW_W     = 32;
    localparam int SLOT_W    = 3;
    localparam int ENTRY_W   = CID_W + WAIT_W;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_INSERTED  = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_REMOVED   = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_WAKE      = 3'd4,
        KIND_IDLE_TICK = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_RD,
        ST_EV,
        ST_FIN
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [CID_W-1:0]   client_id;
        logic [WAIT_W-1:0]  wait_ms;
    } req_t;

    typedef struct packed {
        kind_t              kind;
        logic [CID_W-1:0]   client_id_out;
        logic [SLOT_W-1:0]  slot_index;
        logic [NOW_W-1:0]   now_ms;
        logic               last;
    } rsp_t;

endpackage

/* rtl/stst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module stst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: hold data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/stst_seq.sv */
// Command sequencer for the sleep timer slot table: busy flags, tick counter,
// slot sweep over the entry RAM, and the result register. Uses stst_pkg.
module stst_seq #(
    parameter int SLOTS = stst_pkg::SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  stst_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output stst_pkg::rsp_t               rsp,
    output logic                         ram_wr_en,
    output logic [IDX_W-1:0]             ram_wr_addr,
    output logic [stst_pkg::ENTRY_W-1:0] ram_wr_data,
    output logic                         ram_rd_en,
    output logic [IDX_W-1:0]             ram_rd_addr,
    input  logic [stst_pkg::ENTRY_W-1:0] ram_rd_data
);

    import stst_pkg::*;

    state_t              state_reg, state_next;
    req_t                cmd_reg, cmd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]    busy_reg, busy_next;
    logic [NOW_W-1:0]    tick_reg, tick_next;
    rsp_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CID_W-1:0]    pend_client_reg, pend_client_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;

    logic                out_free;
    logic                out_load;
    logic                idx_last;
    logic                adv;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [CID_W-1:0]    ent_client;
    logic [WAIT_W-1:0]   ent_wait;

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign idx_last   = (idx_reg == IDX_W'(SLOTS - 1));
    assign ent_client = ram_rd_data[ENTRY_W-1:WAIT_W];
    assign ent_wait   = ram_rd_data[WAIT_W-1:0];
    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Next state, RAM access and result generation
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        busy_next        = busy_reg;
        tick_next        = tick_reg;
        pend_valid_next  = pend_valid_reg;
        pend_client_next = pend_client_reg;
        pend_slot_next   = pend_slot_reg;
        out_load         = 1'b0;
        out_next         = out_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = idx_reg;
        adv              = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    unique case (req.func)
                        FUNC_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = ST_RD;
                        end
                        FUNC_INSERT: state_next = ST_INS;
                        FUNC_REMOVE: state_next = ST_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_INS:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_next               = '0;
                    out_next.client_id_out = cmd_reg.client_id;
                    out_next.now_ms        = tick_reg;
                    out_next.last          = 1'b1;
                    if (free_found)
                    begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = free_idx;
                        ram_wr_data         = {cmd_reg.client_id, cmd_reg.wait_ms};
                        busy_next[free_idx] = 1'b1;
                        out_next.kind       = KIND_INSERTED;
                        out_next.slot_index = SLOT_W'(free_idx);
                    end
                    else
                    begin
                        out_next.kind = KIND_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RD:
            begin
                // Fetch busy slots, skip free ones
                if (busy_reg[idx_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_EV;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            ST_EV:
            begin
                if (cmd_reg.func == FUNC_TICK)
                begin
                    if (ent_wait <= WAIT_W'(1))
                    begin
                        // Wake: flush the previous wake (not last), hold this one
                        if (!pend_valid_reg || out_free)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_load               = 1'b1;
                                out_next               = '0;
                                out_next.kind          = KIND_WAKE;
                                out_next.client_id_out = pend_client_reg;
                                out_next.slot_index    = pend_slot_reg;
                                out_next.now_ms        = tick_reg;
                                out_next.last          = 1'b0;
                            end
                            pend_valid_next    = 1'b1;
                            pend_client_next   = ent_client;
                            pend_slot_next     = SLOT_W'(idx_reg);
                            busy_next[idx_reg] = 1'b0;
                            adv                = 1'b1;
                        end
                    end
                    else
                    begin
                        // Decrement and write back
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {ent_client, ent_wait - 1'b1};
                        adv         = 1'b1;
                    end
                end
                else
                begin
                    if (ent_client == cmd_reg.client_id)
                    begin
                        if (out_free)
                        begin
                            out_load               = 1'b1;
                            out_next               = '0;
                            out_next.kind          = KIND_REMOVED;
                            out_next.client_id_out = cmd_reg.client_id;
                            out_next.slot_index    = SLOT_W'(idx_reg);
                            out_next.now_ms        = tick_reg;
                            out_next.last          = 1'b1;
                            busy_next[idx_reg]     = 1'b0;
                            state_next             = ST_IDLE;
                        end
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_next        = '0;
                    out_next.now_ms = tick_reg;
                    out_next.last   = 1'b1;
                    if (cmd_reg.func == FUNC_TICK)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next.kind          = KIND_WAKE;
                            out_next.client_id_out = pend_client_reg;
                            out_next.slot_index    = pend_slot_reg;
                        end
                        else
                        begin
                            out_next.kind = KIND_IDLE_TICK;
                        end
                    end
                    else
                    begin
                        out_next.kind          = KIND_NOT_FOUND;
                        out_next.client_id_out = cmd_reg.client_id;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Step to the next slot or finish the sweep
        if (adv)
        begin
            if (idx_last)
            begin
                state_next = ST_FIN;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_RD;
            end
        end

        // Result register: load a new transaction or drop the taken one
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            busy_reg       <= '0;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            busy_reg       <= busy_next;
            tick_reg       <= tick_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        out_reg         <= out_next;
        pend_client_reg <= pend_client_next;
        pend_slot_reg   <= pend_slot_next;
    end

endmodule

/* rtl/sleep_timer_slot_table.sv */
// Top level of the sleep timer slot table: sequencer plus slot entry RAM.
// Depends on stst_pkg, stst_ram and stst_seq.
//
// A table of SLOTS sleep slots. Insert takes the lowest free slot, remove
// frees the lowest slot holding the client id, and a tick advances now_ms
// and counts every busy slot down, giving one wake transaction per expired
// slot in index order with last set on the final one (or a single
// tick-without-wake transaction). Client id and remaining wait live in one
// SLOTS-deep RAM with a registered read; busy flags are flip-flops cleared by
// reset. One command is handled at a time and req_stall is high until its
// final result is loaded. Tick and remove sweep the slots through the single
// RAM read port, skipping free slots and reading each busy one; a remove ends
// early at the match. Result delivery is held back only while rsp_stall holds.
module sleep_timer_slot_table #(
    parameter int SLOTS = stst_pkg::SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  stst_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output stst_pkg::rsp_t rsp
);

    import stst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    // Sequencer
    stst_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Slot entries: {client id, remaining wait}
    stst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The sweep never reads and writes the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)))
        else $error("entry RAM read and write to the same slot");

    // An accepted insert or remove always occupies the sequencer next cycle
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall &&
         (req.func == FUNC_INSERT || req.func == FUNC_REMOVE)) |=> req_stall)
        else $error("command accepted without occupying the sequencer");

    // Only wake transactions may be non-final
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind != KIND_WAKE) |-> rsp.last)
        else $error("non-wake transaction without last");

    // A new result is loaded only while the sequencer still owns a command
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared with no command in progress");

endmodule
